/* design/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants of the streaming top-K selection block.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int DEFAULT_TOP_K        = 5;
    localparam int DEFAULT_MAX_ELEMENTS = 4096;

    localparam int SCORE_W = 8;
    localparam int INDEX_W = 12;
    localparam int RANK_W  = 3;

    // One held entry of the top list.
    typedef struct packed {
        logic                      valid;
        logic [INDEX_W-1:0]        index;
        logic signed [SCORE_W-1:0] score;
    } slot_t;

    // Control from the input register to the slot list.
    typedef struct packed {
        logic take;
        logic last;
    } tks_ctrl_t;

endpackage

/* design/streaming_top_k_select_core.sv */
// ----------------------------------------------------------------------------
// streaming_top_k_select_core
// Streaming stable top-K selection over signed 8-bit scores, one list of
// TOP_K ranked results per sample.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_      | in        | tdata[7:0] score, tlast last element of the sample
//  m_      | out       | tdata rank/class_index/top_score, tuser filled/overflow,
//          |           | tlast final rank of the sample
//
// One score is taken per cycle; insertion into the sorted slot list is done
// in parallel from the input register into the slot registers. A last element
// copies the list into an output shift register, which then gives TOP_K items,
// one per cycle while m_tready is high. Scores of the next sample keep flowing
// meanwhile; only its last element waits until the previous list is out.
// Reset (aresetn low, synchronous) empties the list and the output.
// ----------------------------------------------------------------------------
module streaming_top_k_select_core
    import tks_pkg::*;
#(
    parameter int TOP_K        = DEFAULT_TOP_K,
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] score
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] rank, [14:3] class_index, [22:15] top_score
    output logic [1:0]  m_tuser,   // [0] filled, [1] index_overflow
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(TOP_K + 1);

    // Input register.
    logic                      in_valid_reg;
    logic signed [SCORE_W-1:0] in_score_reg;
    logic                      in_last_reg;

    logic      advance;
    logic      can_load;
    tks_ctrl_t ctrl;
    slot_t     list [TOP_K];
    logic      overflow;

    // Output shift register.
    slot_t            snap_reg [TOP_K];
    logic             snap_ovf_reg;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] rank_reg;
    logic [31:0]      rank_ext;
    logic             m_take;

    assign m_take   = m_tvalid && m_tready;
    assign can_load = (remain_reg == '0) || ((remain_reg == CNT_W'(1)) && m_tready);
    assign advance  = in_valid_reg && (!in_last_reg || can_load);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_score_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    assign ctrl.take = advance;
    assign ctrl.last = in_last_reg;

    tks_slots #(
        .TOP_K        (TOP_K),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .score    (in_score_reg),
        .list_out (list),
        .overflow (overflow)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
            rank_reg   <= '0;
        end else if (advance && in_last_reg) begin
            remain_reg <= CNT_W'(TOP_K);
            rank_reg   <= '0;
        end else if (m_take) begin
            remain_reg <= remain_reg - 1'b1;
            rank_reg   <= rank_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            snap_ovf_reg <= overflow;
            for (int i = 0; i < TOP_K; i++) begin
                snap_reg[i] <= list[i];
            end
        end else if (m_take) begin
            for (int i = 0; i < TOP_K - 1; i++) begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    assign rank_ext = 32'(rank_reg);
    assign m_tvalid = remain_reg != '0;
    assign m_tlast  = remain_reg == CNT_W'(1);

    // An empty slot reads as zero in its class_index and top_score fields.
    always_comb begin
        m_tdata = '0;
        m_tdata[RANK_W-1:0] = rank_ext[RANK_W-1:0];
        if (snap_reg[0].valid) begin
            m_tdata[RANK_W +: INDEX_W]           = snap_reg[0].index;
            m_tdata[RANK_W + INDEX_W +: SCORE_W] = snap_reg[0].score;
        end
        m_tuser = {snap_ovf_reg, snap_reg[0].valid};
    end

endmodule

/* design/tks_slots.sv */
// ----------------------------------------------------------------------------
// tks_slots
// Sorted list of the highest scores of the current sample, with the element
// counter and overflow flag. Inserts one score per cycle while ctrl.take is high.
// ----------------------------------------------------------------------------
module tks_slots
    import tks_pkg::*;
#(
    parameter int TOP_K        = DEFAULT_TOP_K,
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tks_ctrl_t                 ctrl,
    input  logic signed [SCORE_W-1:0] score,
    output slot_t                     list_out [TOP_K],
    output logic                      overflow
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    slot_t            slot_reg  [TOP_K];
    slot_t            slot_next [TOP_K];
    slot_t            ins_list  [TOP_K];
    logic [TOP_K-1:0] gt;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             room;
    logic [31:0]      cnt_ext;
    logic [INDEX_W-1:0] new_index;

    assign room      = cnt_reg < CNT_W'(MAX_ELEMENTS);
    assign cnt_ext   = 32'(cnt_reg);
    assign new_index = cnt_ext[INDEX_W-1:0];

    // The list is sorted with valid entries first, so gt is a thermometer
    // code: the first set bit is the insertion point.
    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            gt[i] = !slot_reg[i].valid || (score > slot_reg[i].score);
        end
    end

    genvar g;
    generate
        for (g = 0; g < TOP_K; g++) begin : g_ins
            if (g == 0) begin : g_head
                always_comb begin
                    if (ctrl.take && room && gt[0]) begin
                        ins_list[0] = '{valid: 1'b1, index: new_index, score: score};
                    end else begin
                        ins_list[0] = slot_reg[0];
                    end
                end
            end else begin : g_body
                always_comb begin
                    if (ctrl.take && room && gt[g]) begin
                        if (gt[g-1]) begin
                            ins_list[g] = slot_reg[g-1];
                        end else begin
                            ins_list[g] = '{valid: 1'b1, index: new_index, score: score};
                        end
                    end else begin
                        ins_list[g] = slot_reg[g];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        for (int i = 0; i < TOP_K; i++) begin
            slot_next[i] = ins_list[i];
        end
        if (ctrl.take) begin
            if (ctrl.last) begin
                // The sample ends here: the list is handed out and cleared.
                cnt_next = '0;
                ovf_next = 1'b0;
                for (int i = 0; i < TOP_K; i++) begin
                    slot_next[i] = '0;
                end
            end else if (room) begin
                cnt_next = cnt_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            for (int i = 0; i < TOP_K; i++) begin
                slot_reg[i] <= '0;
            end
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            for (int i = 0; i < TOP_K; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            list_out[i] = ins_list[i];
        end
    end

    assign overflow = ovf_reg || !room;

endmodule

/* tb/sv/tb_streaming_top_k_select_core.sv */
// ----------------------------------------------------------------------------
// tb_streaming_top_k_select_core
// Self-checking bench for the streaming top-K selection core. Samples of
// signed scores are streamed in with random gaps. The ranked lists that come
// back are checked against a behavioral ranking kept in the bench. Directed
// samples cover short lists, ties and the sign extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_streaming_top_k_select_core;
    import tks_pkg::*;

    localparam int TOP_K        = DEFAULT_TOP_K;
    localparam int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } score_item_t;

    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic [INDEX_W-1:0]        class_index;
        logic signed [SCORE_W-1:0] top_score;
        logic                      filled;
        logic                      overflow;
        logic                      last;
    } rank_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] score
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [2:0] rank, [14:3] class_index, [22:15] top_score
    logic [1:0]  m_tuser;         // [0] filled, [1] index_overflow
    logic        m_tlast;

    streaming_top_k_select_core #(
        .TOP_K        (TOP_K),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    score_item_t  pending_scores[$];
    rank_result_t expected_ranks[$];

    // Ranking state of the bench.
    slot_t held[TOP_K];
    int    taken_in_sample = 0;
    logic  sample_overflow = 1'b0;

    score_item_t cur_item;
    int send_gap     = 0;
    int send_calm    = 0;
    int stall_left   = 0;
    int stall_calm   = 0;
    int items_taken  = 0;
    int samples_done = 0;
    int overflow_samples = 0;
    int results_checked  = 0;
    int errors           = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(50_000_000);
        $display("tb_streaming_top_k_select_core: done, errors");
        $finish;
    end

    function automatic void clear_ranking();
        for (int i = 0; i < TOP_K; i++) begin
            held[i] = '0;
        end
        taken_in_sample = 0;
        sample_overflow = 1'b0;
    endfunction

    // Takes one score into the ranking. A score only moves ahead of a held
    // one when it is strictly greater, so equal scores keep arrival order.
    function automatic void rank_score(score_item_t item);
        int pos;
        rank_result_t res;
        if (taken_in_sample < MAX_ELEMENTS) begin
            pos = 0;
            while (pos < TOP_K && held[pos].valid &&
                   !($signed(item.score) > $signed(held[pos].score))) begin
                pos++;
            end
            if (pos < TOP_K) begin
                for (int i = TOP_K - 1; i > pos; i--) begin
                    held[i] = held[i-1];
                end
                held[pos].valid = 1'b1;
                held[pos].index = taken_in_sample[INDEX_W-1:0];
                held[pos].score = item.score;
            end
            taken_in_sample++;
        end else begin
            sample_overflow = 1'b1;
        end
        if (item.last) begin
            for (int k = 0; k < TOP_K; k++) begin
                res.rank        = k[RANK_W-1:0];
                res.filled      = held[k].valid;
                res.class_index = held[k].valid ? held[k].index : '0;
                res.top_score   = held[k].valid ? held[k].score : '0;
                res.overflow    = sample_overflow;
                res.last        = (k == TOP_K - 1);
                expected_ranks = {expected_ranks, res};
            end
            samples_done++;
            if (sample_overflow) overflow_samples++;
            clear_ranking();
        end
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void report_error(string what, rank_result_t want, rank_result_t got);
        errors++;
        if (errors <= 10) begin
            $display("%s at %0t", what, $realtime);
            $display("  expected rank %0d index %0d score %0d filled %0b ovf %0b last %0b",
                     want.rank, want.class_index, want.top_score,
                     want.filled, want.overflow, want.last);
            $display("  actual   rank %0d index %0d score %0d filled %0b ovf %0b last %0b",
                     got.rank, got.class_index, got.top_score,
                     got.filled, got.overflow, got.last);
        end
    endfunction

    // Input side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                rank_score(cur_item);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_scores.size() > 0) begin
                    cur_item = pending_scores.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_item.score;
                    s_tlast  <= cur_item.last;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side.
    always @(posedge aclk) begin
        rank_result_t got;
        rank_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.rank        = m_tdata[2:0];
                got.class_index = m_tdata[14:3];
                got.top_score   = m_tdata[22:15];
                got.filled      = m_tuser[0];
                got.overflow    = m_tuser[1];
                got.last        = m_tlast;
                if (expected_ranks.size() == 0) begin
                    report_error("result with nothing expected", '0, got);
                end else begin
                    want = expected_ranks.pop_front();
                    results_checked++;
                    if (got !== want) report_error("result mismatch", want, got);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap(stall_calm);
            end
        end
    end

    task automatic add_item(int score, bit last);
        score_item_t item;
        item.score = score[SCORE_W-1:0];
        item.last  = last;
        pending_scores = {pending_scores, item};
    endtask

    initial begin
        int random_items;
        int len;
        int spread;
        clear_ranking();

        // One-element sample: four ranks stay unfilled.
        add_item(-128, 1);
        // Short sample with the positive extreme and both sides of zero.
        add_item(127, 0);
        add_item(-1, 0);
        add_item(0, 1);
        // All scores equal: earlier indices must win.
        for (int i = 0; i < 7; i++) add_item(5, i == 6);
        // Rising and mixed order.
        add_item(-128, 0);
        add_item(-1, 0);
        add_item(0, 0);
        add_item(1, 0);
        add_item(127, 0);
        add_item(64, 0);
        add_item(127, 0);
        add_item(2, 1);

        random_items = 0;
        while (random_items < 180) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 7);
            spread = $urandom_range(0, 2);
            for (int i = 0; i < len; i++) begin
                if (spread == 0) add_item($urandom_range(0, 3) - 2, i == len - 1);
                else add_item($urandom_range(0, 255) - 128, i == len - 1);
                random_items++;
            end
        end

        while (pending_scores.size() > 0 || s_tvalid) @(negedge aclk);
        while (expected_ranks.size() > 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (expected_ranks.size() != 0) begin
            errors++;
            $display("%0d results never arrived", expected_ranks.size());
        end

        $display("Streamed %0d scores in %0d samples, %0d of them past the element limit.",
                 items_taken, samples_done, overflow_samples);
        $display("Checked %0d ranked results, %0d errors.", results_checked, errors);
        if (errors == 0) begin
            $display("tb_streaming_top_k_select_core: done, clean");
        end else begin
            $display("tb_streaming_top_k_select_core: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tks_pkg.sv
design/tks_slots.sv
design/streaming_top_k_select_core.sv
tb/sv/tb_streaming_top_k_select_core.sv
